FILE: sv/ethash_mix_core_macros.svh
// Assertion macros shared by the mixing core
`ifndef ETHASH_MIX_CORE_MACROS_SVH
`define ETHASH_MIX_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define EMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define EMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ethmix_pkg.sv
// Types and constants for the hashimoto mixing core
`timescale 1ns / 1ps

package ethmix_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SEED_WORDS = 16;
  localparam logic [DATA_W-1:0] FNV_MULT = 32'h0100_0193;

  // input command codes (travel on in_tuser)
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_PAGE = 1'b1;

  // result kind codes (travel on out_tuser)
  localparam logic KIND_INDEX  = 1'b0;
  localparam logic KIND_DIGEST = 1'b1;

  typedef enum logic [3:0] {
    ST_SEED,      // wait for seed words
    ST_SEED_HI,   // write the second copy of a seed word
    ST_IDX_RD,    // read the mix word that feeds the page index
    ST_IDX_MUL,   // FNV of the index seed with the mix word
    ST_IDX_DIV,   // restoring remainder, one bit a cycle
    ST_IDX_OUT,   // hand the page index to the output register
    ST_PAGE,      // wait for page words
    ST_PAGE_MUL,  // fold one page word into the mix
    ST_DG_RD,     // read one mix word for the digest
    ST_DG_USE,    // fold it into the digest word
    ST_DG_OUT     // hand the digest word to the output register
  } mix_state_t;

endpackage

FILE: sv/ethash_mix_core.sv
// Ethash hashimoto mixing loop: seed load, page index requests, FNV fold, digest
//
// Input channel (in_*): one 32-bit word per transaction, in_tuser selects seed
// word (0) or dataset page word (1). Sixteen seed words start a hash. The core
// then issues a page index on the output channel (out_tuser = 0) and expects
// PAGE_WORDS page words back; this repeats ACCESSES times. After the last page
// it issues PAGE_WORDS/4 digest words (out_tuser = 1), out_tlast on the final
// one, and waits for the next seed. A word of the wrong kind is dropped.
// Sequence: a seed word is one mix write, or two (a second copy) on the one RAM
// port; a page word is a RAM read, then multiply and write back. A page index
// follows the word that finished the page (or the seed when PAGE_WORDS is 32)
// through fold or second write, read, FNV multiply, a bit-serial remainder
// over all 32 dividend bits by cfg_wdata's dataset size, then the output load.
// Each digest word is four reads folded through the one shared FNV
// multiplier. The core takes no input while it computes.
// Results sit in an output register; a stalled receiver holds the core at its
// next result, while page words are still taken behind a waiting index.
// Reset (rst_n low, synchronous) returns to waiting for seed words and sets
// the dataset size to 1; the mix RAM is not cleared, the seed fills it.
`timescale 1ns / 1ps

module ethash_mix_core
  import ethmix_pkg::*;
#(
  parameter int unsigned ACCESSES   = 64,
  parameter int unsigned PAGE_WORDS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: dataset_items
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] data_word
  input  logic              in_tuser,   // [0] command
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] value
  output logic              out_tuser,  // [0] kind
  output logic              out_tlast
);

`include "ethash_mix_core_macros.svh"

  localparam int unsigned MIX_AW  = $clog2(PAGE_WORDS);
  localparam int unsigned ACC_W   = (ACCESSES > 1) ? $clog2(ACCESSES) : 1;
  localparam int unsigned DIV_W   = $clog2(DATA_W);
  localparam logic [5:0]        PW6      = 6'(PAGE_WORDS);
  localparam logic [MIX_AW-1:0] PW_LAST  = MIX_AW'(PAGE_WORDS - 1);
  localparam logic [MIX_AW-1:0] DG_LAST  = MIX_AW'((PAGE_WORDS / 4) * 4 - 1);
  localparam logic [ACC_W-1:0]  ACC_LAST = ACC_W'(ACCESSES - 1);
  localparam logic [DIV_W-1:0]  DIV_LAST = DIV_W'(DATA_W - 1);
  localparam logic [3:0]        SEED_LAST = 4'(SEED_WORDS - 1);

  mix_state_t st_r, st_nxt;

  logic [DATA_W-1:0] items_r;
  logic [DATA_W-1:0] seed_start_r, seed_start_nxt;
  logic [3:0]        seed_pos_r, seed_pos_nxt;
  logic [MIX_AW-1:0] page_pos_r, page_pos_nxt;
  logic [ACC_W-1:0]  acc_num_r, acc_num_nxt;
  logic [MIX_AW-1:0] slot_r, slot_nxt;
  logic [MIX_AW-1:0] dg_addr_r, dg_addr_nxt;
  logic [DATA_W-1:0] dg_h_r, dg_h_nxt;
  logic [DATA_W-1:0] d_r, d_nxt;
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_cnt_r, div_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;

  // mix RAM, one write and one registered read port
  logic [DATA_W-1:0] mix_mem [PAGE_WORDS];
  logic [DATA_W-1:0] rd_r;
  logic              mem_we;
  logic [MIX_AW-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [MIX_AW-1:0] mem_raddr;

  // shared FNV multiplier
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_p;

  logic              in_acc;
  logic              out_free;
  logic [5:0]        pos_hi;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_sub;

  assign mul_p    = mul_a * FNV_MULT;
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign pos_hi   = {2'b00, seed_pos_r} + 6'd16;
  assign trial     = {rem_r, dvd_r[DATA_W-1]};
  assign trial_sub = trial - {1'b0, items_r};

  assign in_tready  = (st_r == ST_SEED) || (st_r == ST_PAGE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    st_nxt         = st_r;
    seed_start_nxt = seed_start_r;
    seed_pos_nxt   = seed_pos_r;
    page_pos_nxt   = page_pos_r;
    acc_num_nxt    = acc_num_r;
    slot_nxt       = slot_r;
    dg_addr_nxt    = dg_addr_r;
    dg_h_nxt       = dg_h_r;
    d_nxt          = d_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = MIX_AW'(seed_pos_r);
    mem_wdata      = in_tdata;
    mem_raddr      = page_pos_r;
    mul_a          = rd_r;

    case (st_r)
      ST_SEED, ST_SEED_HI: begin
        if (st_r == ST_SEED_HI || (in_acc && in_tuser == CMD_SEED)) begin
          if (st_r == ST_SEED) begin
            d_nxt = in_tdata;
            if (seed_pos_r == 4'd0) begin
              seed_start_nxt = in_tdata;
            end
            mem_we = ({2'b00, seed_pos_r} < PW6);
          end else begin
            mem_we    = 1'b1;
            mem_waddr = MIX_AW'(pos_hi);
            mem_wdata = d_r;
          end
          if (st_r == ST_SEED && pos_hi < PW6) begin
            st_nxt = ST_SEED_HI;
          end else if (seed_pos_r == SEED_LAST) begin
            seed_pos_nxt = '0;
            page_pos_nxt = '0;
            acc_num_nxt  = '0;
            slot_nxt     = '0;
            st_nxt       = ST_IDX_RD;
          end else begin
            seed_pos_nxt = seed_pos_r + 4'd1;
            st_nxt       = ST_SEED;
          end
        end
      end

      ST_IDX_RD: begin
        mem_raddr = slot_r;
        st_nxt    = ST_IDX_MUL;
      end

      ST_IDX_MUL: begin
        mul_a       = DATA_W'(acc_num_r) ^ seed_start_r;
        dvd_nxt     = mul_p ^ rd_r;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        st_nxt      = ST_IDX_DIV;
      end

      ST_IDX_DIV: begin
        // restoring step: remainder stays below the divisor
        if (trial >= {1'b0, items_r}) begin
          rem_nxt = trial_sub[DATA_W-1:0];
        end else begin
          rem_nxt = trial[DATA_W-1:0];
        end
        dvd_nxt     = {dvd_r[DATA_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          st_nxt = ST_IDX_OUT;
        end
      end

      ST_IDX_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_INDEX;
          out_value_nxt = (items_r == '0) ? '0 : rem_r;
          out_last_nxt  = 1'b0;
          st_nxt        = ST_PAGE;
        end
      end

      ST_PAGE: begin
        mem_raddr = page_pos_r;
        if (in_acc && in_tuser == CMD_PAGE) begin
          d_nxt  = in_tdata;
          st_nxt = ST_PAGE_MUL;
        end
      end

      ST_PAGE_MUL: begin
        mul_a     = rd_r;
        mem_we    = 1'b1;
        mem_waddr = page_pos_r;
        mem_wdata = mul_p ^ d_r;
        if (page_pos_r == PW_LAST) begin
          page_pos_nxt = '0;
          if (acc_num_r == ACC_LAST) begin
            acc_num_nxt = '0;
            slot_nxt    = '0;
            dg_addr_nxt = '0;
            st_nxt      = ST_DG_RD;
          end else begin
            acc_num_nxt = acc_num_r + 1'b1;
            slot_nxt    = (slot_r == PW_LAST) ? '0 : slot_r + 1'b1;
            st_nxt      = ST_IDX_RD;
          end
        end else begin
          page_pos_nxt = page_pos_r + 1'b1;
          st_nxt       = ST_PAGE;
        end
      end

      ST_DG_RD: begin
        mem_raddr = dg_addr_r;
        st_nxt    = ST_DG_USE;
      end

      ST_DG_USE: begin
        mul_a = dg_h_r;
        if (dg_addr_r[1:0] == 2'd0) begin
          dg_h_nxt = rd_r;
        end else begin
          dg_h_nxt = mul_p ^ rd_r;
        end
        if (dg_addr_r[1:0] == 2'd3) begin
          st_nxt = ST_DG_OUT;
        end else begin
          dg_addr_nxt = dg_addr_r + 1'b1;
          st_nxt      = ST_DG_RD;
        end
      end

      ST_DG_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DIGEST;
          out_value_nxt = dg_h_r;
          out_last_nxt  = (dg_addr_r == DG_LAST);
          if (dg_addr_r == DG_LAST) begin
            st_nxt = ST_SEED;
          end else begin
            dg_addr_nxt = dg_addr_r + 1'b1;
            st_nxt      = ST_DG_RD;
          end
        end
      end

      default: begin
        st_nxt = ST_SEED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_SEED;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_r      <= 32'd1;
      seed_start_r <= '0;
      seed_pos_r   <= '0;
      page_pos_r   <= '0;
      acc_num_r    <= '0;
      slot_r       <= '0;
      dg_addr_r    <= '0;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        items_r <= cfg_wdata;
      end
      seed_start_r <= seed_start_nxt;
      seed_pos_r   <= seed_pos_nxt;
      page_pos_r   <= page_pos_nxt;
      acc_num_r    <= acc_num_nxt;
      slot_r       <= slot_nxt;
      dg_addr_r    <= dg_addr_nxt;
      div_cnt_r    <= div_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dg_h_r      <= dg_h_nxt;
    d_r         <= d_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    out_value_r <= out_value_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mix_mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mix_mem[mem_raddr];
  end

  `EMC_ASSERT_NOW(a_index_not_last, out_tvalid && out_tuser == KIND_INDEX, !out_tlast, "page index marked last")
  `EMC_ASSERT_NEXT(a_page_fold, in_acc && st_r == ST_PAGE && in_tuser == CMD_PAGE, st_r == ST_PAGE_MUL, "page word not folded next cycle")
  `EMC_ASSERT_NEXT(a_div_done, st_r == ST_IDX_DIV && div_cnt_r == DIV_LAST, st_r == ST_IDX_OUT, "remainder did not finish after full width")
  `EMC_ASSERT_NEXT(a_digest_last, st_r == ST_DG_OUT && out_free && dg_addr_r == DG_LAST, out_tvalid && out_tlast && st_r == ST_SEED, "final digest word not flagged")

endmodule
